[rtl/core/tiffop_pkg.sv]
// ---------------------------------------------------------------------------
// tiffop_pkg
// Shared constants, codes and control/status structs for the orientation
// tag patcher.
// ---------------------------------------------------------------------------
package tiffop_pkg;

   // buffer sizing
   localparam int MAX_BYTES = 65536;
   localparam int ADDR_W    = $clog2(MAX_BYTES);
   localparam int LEN_W     = $clog2(MAX_BYTES + 1);
   // width of ifd position plus entry table size (count * 12 needs 20 bits)
   localparam int OVR_W     = ((LEN_W > 20) ? LEN_W : 20) + 1;

   // result status codes
   localparam int STATUS_W = 3;
   localparam logic [STATUS_W-1:0] ST_PATCHED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_TIFF  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_IFD_BAD   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERRUN   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd5;

   // tiff constants
   localparam logic [15:0] ORIENT_TAG      = 16'd274;
   localparam logic [15:0] ORIENT_TYPE     = 16'd3;
   localparam logic [31:0] ORIENT_COUNT    = 32'd1;
   localparam logic [15:0] ORIENT_TOP_LEFT = 16'd1;
   localparam int          ENTRY_BYTES     = 12;
   localparam int          MIN_LEN         = 8;
   localparam logic [31:0] SIG_MM          = 32'h4D4D_002A;
   localparam logic [31:0] SIG_II          = 32'h4949_2A00;

   // read address sources
   localparam logic [1:0] ADDR_SRC_ZERO  = 2'd0;
   localparam logic [1:0] ADDR_SRC_IFD   = 2'd1;
   localparam logic [1:0] ADDR_SRC_ENTRY = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic                load_en;
      logic                rd_en;
      logic                addr_ld;
      logic [1:0]          addr_src;
      logic                sig_mode;
      logic                be_ld;
      logic                pos_ld_ifd;
      logic                pos_step;
      logic                cnt_ld;
      logic                cnt_dec;
      logic                emit;
      logic [STATUS_W-1:0] status;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic ovf;
      logic too_short;
      logic sig_ok;
      logic ifd_bad;
      logic overrun;
      logic cnt_zero;
      logic tagtype_ok;
      logic ecnt_ok;
      logic out_busy;
   } dp_stat_type;

endpackage

[rtl/core/tiffop_if.sv]
// ---------------------------------------------------------------------------
// tiffop_if
// Valid/ready channel interfaces for byte input and result output.
// ---------------------------------------------------------------------------
interface tiffop_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface tiffop_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] patch_offset;
   logic [7:0]  patch_first_byte;
   logic [7:0]  patch_second_byte;
   logic        big_endian;

   modport source (output valid, output status, output patch_offset,
                   output patch_first_byte, output patch_second_byte,
                   output big_endian, input ready);
   modport sink   (input valid, input status, input patch_offset,
                   input patch_first_byte, input patch_second_byte,
                   input big_endian, output ready);
endinterface

[rtl/core/tiff_orientation_tag_patcher.sv]
// ---------------------------------------------------------------------------
// tiff_orientation_tag_patcher
// Locates the IFD0 orientation entry of a TIFF/EXIF block and reports where
// and what to write to reset it to top-left.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries the block one byte per transaction; last marks the final
//   byte. While loading, one byte is taken every cycle.
//   After the last byte the input stalls while the search runs, then one
//   transaction on rsp_ch carries status, value field offset, the two bytes
//   encoding value 1 in the file's byte order, and the byte order flag.
//   The search reads the byte store one byte per cycle while it fetches a
//   field: signature, ifd offset, entry count, then each entry's tag and
//   type and, where they match, its count; it then issues the result.
//   A new block may be loaded while the previous result waits in the output
//   register; a stalled receiver holds the result and only delays the issue
//   of the next one. Bytes beyond the store capacity are dropped and flagged.
//   Reset empties the store and clears the pending result; no clearing pass.
// ---------------------------------------------------------------------------
module tiff_orientation_tag_patcher (
   input  logic          clock,
   input  logic          reset,
   tiffop_req_if.sink    req_ch,
   tiffop_rsp_if.source  rsp_ch
);

   tiffop_pkg::ctl_cmd_type cmd;
   tiffop_pkg::dp_stat_type stat;

   // sequencer
   tiffop_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // store, checks and result register
   tiffop_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_data_byte         (req_ch.data_byte),
      .rsp_ready             (rsp_ch.ready),
      .rsp_valid             (rsp_ch.valid),
      .rsp_status            (rsp_ch.status),
      .rsp_patch_offset      (rsp_ch.patch_offset),
      .rsp_patch_first_byte  (rsp_ch.patch_first_byte),
      .rsp_patch_second_byte (rsp_ch.patch_second_byte),
      .rsp_big_endian        (rsp_ch.big_endian)
   );

endmodule

[rtl/core/tiffop_ctrl.sv]
// ---------------------------------------------------------------------------
// tiffop_ctrl
// Sequencer: loads bytes, then walks signature, ifd offset, entry count and
// the entry table by issuing byte reads to the datapath.
// ---------------------------------------------------------------------------
module tiffop_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   output tiffop_pkg::ctl_cmd_type cmd,
   input  tiffop_pkg::dp_stat_type stat
);

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_SIG   = 4'd2;
   localparam logic [3:0] S_IFD   = 4'd3;
   localparam logic [3:0] S_CNT   = 4'd4;
   localparam logic [3:0] S_OVR   = 4'd5;
   localparam logic [3:0] S_ENT   = 4'd6;
   localparam logic [3:0] S_ECNT  = 4'd7;
   localparam logic [3:0] S_NEXT  = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;

   // bytes per fetch
   localparam logic [2:0] N_WORD = 3'd4;
   localparam logic [2:0] N_HALF = 3'd2;

   logic [3:0]                      state_ff, state_in;
   logic [2:0]                      fcnt_ff, fcnt_in;
   logic [tiffop_pkg::STATUS_W-1:0] st_ff, st_in;
   logic [2:0]                      fetch_n;
   logic                            fetch_done;

   // fetch length of the current state
   always_comb begin
      case (state_ff)
         S_CNT:   fetch_n = N_HALF;
         default: fetch_n = N_WORD;
      endcase
   end

   assign fetch_done = (fcnt_ff == fetch_n + 3'd1);

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      fcnt_in   = 3'd0;
      st_in     = st_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.status = st_ff;
      case (state_ff)
         S_LOAD: begin
            req_ready   = 1'b1;
            cmd.load_en = req_valid;
            if (req_valid && req_last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.ovf) begin
               st_in    = tiffop_pkg::ST_TOO_LONG;
               state_in = S_EMIT;
            end else if (stat.too_short) begin
               st_in    = tiffop_pkg::ST_NOT_TIFF;
               state_in = S_EMIT;
            end else begin
               cmd.addr_ld  = 1'b1;
               cmd.addr_src = tiffop_pkg::ADDR_SRC_ZERO;
               state_in     = S_SIG;
            end
         end
         S_SIG: begin
            cmd.sig_mode = 1'b1;
            cmd.rd_en    = (fcnt_ff < fetch_n);
            fcnt_in      = fcnt_ff + 3'd1;
            if (fetch_done) begin
               fcnt_in = 3'd0;
               if (stat.sig_ok) begin
                  cmd.be_ld = 1'b1;
                  state_in  = S_IFD;
               end else begin
                  st_in    = tiffop_pkg::ST_NOT_TIFF;
                  state_in = S_EMIT;
               end
            end
         end
         S_IFD: begin
            cmd.rd_en = (fcnt_ff < fetch_n);
            fcnt_in   = fcnt_ff + 3'd1;
            if (fetch_done) begin
               fcnt_in = 3'd0;
               if (stat.ifd_bad) begin
                  st_in    = tiffop_pkg::ST_IFD_BAD;
                  state_in = S_EMIT;
               end else begin
                  cmd.addr_ld    = 1'b1;
                  cmd.addr_src   = tiffop_pkg::ADDR_SRC_IFD;
                  cmd.pos_ld_ifd = 1'b1;
                  state_in       = S_CNT;
               end
            end
         end
         S_CNT: begin
            cmd.rd_en = (fcnt_ff < fetch_n);
            fcnt_in   = fcnt_ff + 3'd1;
            if (fetch_done) begin
               fcnt_in    = 3'd0;
               cmd.cnt_ld = 1'b1;
               state_in   = S_OVR;
            end
         end
         S_OVR: begin
            if (stat.overrun) begin
               st_in    = tiffop_pkg::ST_OVERRUN;
               state_in = S_EMIT;
            end else if (stat.cnt_zero) begin
               st_in    = tiffop_pkg::ST_NOT_FOUND;
               state_in = S_EMIT;
            end else begin
               cmd.addr_ld  = 1'b1;
               cmd.addr_src = tiffop_pkg::ADDR_SRC_ENTRY;
               state_in     = S_ENT;
            end
         end
         S_ENT: begin
            cmd.rd_en = (fcnt_ff < fetch_n);
            fcnt_in   = fcnt_ff + 3'd1;
            if (fetch_done) begin
               fcnt_in = 3'd0;
               if (stat.tagtype_ok) begin
                  state_in = S_ECNT;
               end else begin
                  cmd.pos_step = 1'b1;
                  cmd.cnt_dec  = 1'b1;
                  state_in     = S_NEXT;
               end
            end
         end
         S_ECNT: begin
            cmd.rd_en = (fcnt_ff < fetch_n);
            fcnt_in   = fcnt_ff + 3'd1;
            if (fetch_done) begin
               fcnt_in = 3'd0;
               if (stat.ecnt_ok) begin
                  st_in    = tiffop_pkg::ST_PATCHED;
                  state_in = S_EMIT;
               end else begin
                  cmd.pos_step = 1'b1;
                  cmd.cnt_dec  = 1'b1;
                  state_in     = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            if (stat.cnt_zero) begin
               st_in    = tiffop_pkg::ST_NOT_FOUND;
               state_in = S_EMIT;
            end else begin
               cmd.addr_ld  = 1'b1;
               cmd.addr_src = tiffop_pkg::ADDR_SRC_ENTRY;
               state_in     = S_ENT;
            end
         end
         S_EMIT: begin
            // wait for the output register to free up
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         fcnt_ff  <= 3'd0;
         st_ff    <= tiffop_pkg::ST_PATCHED;
      end else begin
         state_ff <= state_in;
         fcnt_ff  <= fcnt_in;
         st_ff    <= st_in;
      end
   end

endmodule

[rtl/core/tiffop_dpath.sv]
// ---------------------------------------------------------------------------
// tiffop_dpath
// Byte store, field assembly, bounds checks and the result register.
// ---------------------------------------------------------------------------
module tiffop_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  tiffop_pkg::ctl_cmd_type cmd,
   output tiffop_pkg::dp_stat_type stat,
   input  logic [7:0]              req_data_byte,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic [15:0]             rsp_patch_offset,
   output logic [7:0]              rsp_patch_first_byte,
   output logic [7:0]              rsp_patch_second_byte,
   output logic                    rsp_big_endian
);

   localparam int ADDR_W = tiffop_pkg::ADDR_W;
   localparam int LEN_W  = tiffop_pkg::LEN_W;
   localparam int OVR_W  = tiffop_pkg::OVR_W;

   logic [7:0]        store_mem [tiffop_pkg::MAX_BYTES];
   logic [7:0]        mem_q_ff;
   logic              mem_vld_ff;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [31:0]       acc_ff, acc_in;
   logic              be_ff;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [15:0]       count_ff, count_in;
   logic [15:0]       val16;
   logic              full;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        status_ff;
   logic [15:0]       offset_ff;
   logic [7:0]        first_ff, second_ff;
   logic              big_ff;
   logic [15:0]       tag_f, type_f;
   logic [OVR_W-1:0]  table_end;
   logic              is_patched;

   assign full = (len_ff == LEN_W'(tiffop_pkg::MAX_BYTES));

   // byte store write during loading
   always_ff @(posedge clock) begin
      if (cmd.load_en && !full) begin
         store_mem[len_ff[ADDR_W-1:0]] <= req_data_byte;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      mem_q_ff <= store_mem[rd_addr_ff];
   end

   // fill level and overflow flag, cleared when the result is issued
   always_comb begin
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (cmd.emit) begin
         len_in = '0;
         ovf_in = 1'b0;
      end else if (cmd.load_en) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            len_in = len_ff + LEN_W'(1);
         end
      end
   end

   // read address
   always_comb begin
      rd_addr_in = rd_addr_ff;
      if (cmd.addr_ld) begin
         case (cmd.addr_src)
            tiffop_pkg::ADDR_SRC_IFD:   rd_addr_in = acc_ff[ADDR_W-1:0];
            tiffop_pkg::ADDR_SRC_ENTRY: rd_addr_in = pos_ff[ADDR_W-1:0];
            default:                    rd_addr_in = '0;
         endcase
      end else if (cmd.rd_en) begin
         rd_addr_in = rd_addr_ff + ADDR_W'(1);
      end
   end

   // field assembly: big endian shifts in at the bottom, little at the top
   always_comb begin
      acc_in = acc_ff;
      if (mem_vld_ff) begin
         if (cmd.sig_mode || be_ff) begin
            acc_in = {acc_ff[23:0], mem_q_ff};
         end else begin
            acc_in = {mem_q_ff, acc_ff[31:8]};
         end
      end
   end

   assign val16  = be_ff ? acc_ff[15:0]  : acc_ff[31:16];
   assign tag_f  = be_ff ? acc_ff[31:16] : acc_ff[15:0];
   assign type_f = be_ff ? acc_ff[15:0]  : acc_ff[31:16];

   // entry position and remaining entry count
   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      if (cmd.pos_ld_ifd) begin
         pos_in = acc_ff[LEN_W-1:0] + LEN_W'(2);
      end else if (cmd.pos_step) begin
         pos_in = pos_ff + LEN_W'(tiffop_pkg::ENTRY_BYTES);
      end
      if (cmd.cnt_ld) begin
         count_in = val16;
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - 16'd1;
      end
   end

   // end of entry table: pos + count * 12
   assign table_end = OVR_W'(pos_ff) + OVR_W'({count_ff, 3'b000})
                    + OVR_W'({count_ff, 2'b00});

   // status towards the controller
   always_comb begin
      stat.ovf        = ovf_ff;
      stat.too_short  = (len_ff < LEN_W'(tiffop_pkg::MIN_LEN));
      stat.sig_ok     = (acc_ff == tiffop_pkg::SIG_MM) || (acc_ff == tiffop_pkg::SIG_II);
      stat.ifd_bad    = ({1'b0, acc_ff} + 33'd2) > 33'(len_ff);
      stat.overrun    = table_end > OVR_W'(len_ff);
      stat.cnt_zero   = (count_ff == 16'd0);
      stat.tagtype_ok = (tag_f == tiffop_pkg::ORIENT_TAG) &&
                        (type_f == tiffop_pkg::ORIENT_TYPE);
      stat.ecnt_ok    = (acc_ff == tiffop_pkg::ORIENT_COUNT);
      stat.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   // output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign is_patched = (cmd.status == tiffop_pkg::ST_PATCHED);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         mem_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         mem_vld_ff   <= cmd.rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      acc_ff     <= acc_in;
      pos_ff     <= pos_in;
      count_ff   <= count_in;
      if (cmd.be_ld) begin
         be_ff <= (acc_ff == tiffop_pkg::SIG_MM);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         status_ff <= cmd.status;
         offset_ff <= is_patched ? 16'(pos_ff + LEN_W'(8)) : 16'd0;
         if (!is_patched) begin
            first_ff  <= 8'd0;
            second_ff <= 8'd0;
         end else if (be_ff) begin
            first_ff  <= tiffop_pkg::ORIENT_TOP_LEFT[15:8];
            second_ff <= tiffop_pkg::ORIENT_TOP_LEFT[7:0];
         end else begin
            first_ff  <= tiffop_pkg::ORIENT_TOP_LEFT[7:0];
            second_ff <= tiffop_pkg::ORIENT_TOP_LEFT[15:8];
         end
         big_ff <= (cmd.status != tiffop_pkg::ST_NOT_TIFF) &&
                   (cmd.status != tiffop_pkg::ST_TOO_LONG) && be_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_patch_offset      = offset_ff;
   assign rsp_patch_first_byte  = first_ff;
   assign rsp_patch_second_byte = second_ff;
   assign rsp_big_endian        = big_ff;

   // fill level never passes capacity
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(tiffop_pkg::MAX_BYTES))
      else $error("fill level beyond capacity");

   // overflow only once the store is full
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> full)
      else $error("overflow flagged with room left");

   // issuing a result starts a fresh block and presents the result
   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_valid_ff && (len_ff == '0) && !ovf_ff))
      else $error("result issue did not restart the block");

endmodule

[dv/tiff_orientation_tag_patcher_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tiff_orientation_tag_patcher_tb
// Streams TIFF/EXIF blocks into the orientation tag patcher one byte per
// transaction and checks each result against an in-bench search of the
// same byte image or against the result given in the directed table. A
// short directed table comes first, then random blocks, mostly well-formed
// with damaged ones mixed in. Both channels stall in random bursts.
// ---------------------------------------------------------------------------
module tiff_orientation_tag_patcher_tb;

   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam int unsigned RANDOM_BYTES = 1370;
   localparam int unsigned MIN_BLOCKS   = 20;

   typedef logic [7:0] byte_q_type [$];

   typedef struct packed {
      logic [tiffop_pkg::STATUS_W-1:0] status;
      logic [15:0]                     offset;
      logic [7:0]                      first_byte;
      logic [7:0]                      second_byte;
      logic                            big_endian;
   } patch_rsp_type;

   typedef struct packed {
      logic [7:0]    data;
      logic          last;
      logic          typed;
      patch_rsp_type rsp;
   } stim_row_type;

   localparam patch_rsp_type NO_PATCH = '0;

   // directed table: a lone byte, then a minimal little-endian block whose
   // single entry is the orientation tag
   localparam stim_row_type DIRECTED_ROWS [0:22] = '{
      '{8'hFF, 1'b1, 1'b1, '{tiffop_pkg::ST_NOT_TIFF, 16'd0, 8'h00, 8'h00, 1'b0}},
      '{8'h49, 1'b0, 1'b0, NO_PATCH},
      '{8'h49, 1'b0, 1'b0, NO_PATCH},
      '{8'h2A, 1'b0, 1'b0, NO_PATCH},
      '{8'h00, 1'b0, 1'b0, NO_PATCH},
      '{8'h08, 1'b0, 1'b0, NO_PATCH},
      '{8'h00, 1'b0, 1'b0, NO_PATCH},
      '{8'h00, 1'b0, 1'b0, NO_PATCH},
      '{8'h00, 1'b0, 1'b0, NO_PATCH},
      '{8'h01, 1'b0, 1'b0, NO_PATCH},
      '{8'h00, 1'b0, 1'b0, NO_PATCH},
      '{8'h12, 1'b0, 1'b0, NO_PATCH},
      '{8'h01, 1'b0, 1'b0, NO_PATCH},
      '{8'h03, 1'b0, 1'b0, NO_PATCH},
      '{8'h00, 1'b0, 1'b0, NO_PATCH},
      '{8'h01, 1'b0, 1'b0, NO_PATCH},
      '{8'h00, 1'b0, 1'b0, NO_PATCH},
      '{8'h00, 1'b0, 1'b0, NO_PATCH},
      '{8'h00, 1'b0, 1'b0, NO_PATCH},
      '{8'h06, 1'b0, 1'b0, NO_PATCH},
      '{8'h00, 1'b0, 1'b0, NO_PATCH},
      '{8'h00, 1'b0, 1'b0, NO_PATCH},
      '{8'h00, 1'b1, 1'b1, '{tiffop_pkg::ST_PATCHED, 16'd18, 8'h01, 8'h00, 1'b0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   tiffop_req_if req_ch ();
   tiffop_rsp_if rsp_ch ();

   tiff_orientation_tag_patcher u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the byte store and load state
   logic [7:0]  store_image [tiffop_pkg::MAX_BYTES];
   int unsigned fill_count = 0;
   bit          spilled    = 1'b0;

   patch_rsp_type pending_patches [$];
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count    = 0;
   bit            quiet_tail     = 1'b0;
   bit            rsp_calm       = 1'b0;
   int unsigned   hold_left      = 0;

   function automatic logic [7:0] peek8(input longint unsigned pos);
      return (pos < tiffop_pkg::MAX_BYTES) ? store_image[int'(pos)] : 8'h00;
   endfunction

   function automatic logic [15:0] peek16(input longint unsigned pos, input bit be);
      return be ? {peek8(pos), peek8(pos + 1)} : {peek8(pos + 1), peek8(pos)};
   endfunction

   function automatic logic [31:0] peek32(input longint unsigned pos, input bit be);
      return be ? {peek16(pos, be), peek16(pos + 2, be)}
                : {peek16(pos + 2, be), peek16(pos, be)};
   endfunction

   // search of the loaded image for the orientation entry
   function automatic patch_rsp_type locate_orientation();
      patch_rsp_type    r;
      bit               be;
      logic [31:0]      ifd;
      logic [15:0]      count;
      longint unsigned  pos;
      longint unsigned  len;
      r   = '0;
      len = fill_count;
      if (spilled) begin
         r.status = tiffop_pkg::ST_TOO_LONG;
         return r;
      end
      if (len < tiffop_pkg::MIN_LEN) begin
         r.status = tiffop_pkg::ST_NOT_TIFF;
         return r;
      end
      if ({peek8(0), peek8(1), peek8(2), peek8(3)} == tiffop_pkg::SIG_MM) begin
         be = 1'b1;
      end else if ({peek8(0), peek8(1), peek8(2), peek8(3)} == tiffop_pkg::SIG_II) begin
         be = 1'b0;
      end else begin
         r.status = tiffop_pkg::ST_NOT_TIFF;
         return r;
      end
      r.big_endian = be;
      ifd = peek32(4, be);
      if (ifd >= 32'h7FFF_FFFF || longint'(ifd) + 2 > len) begin
         r.status = tiffop_pkg::ST_IFD_BAD;
         return r;
      end
      count = peek16(ifd, be);
      pos   = longint'(ifd) + 2;
      if (pos + longint'(count) * tiffop_pkg::ENTRY_BYTES > len) begin
         r.status = tiffop_pkg::ST_OVERRUN;
         return r;
      end
      // first matching entry wins
      for (int i = 0; i < int'(count); i++) begin
         if (peek16(pos, be) == tiffop_pkg::ORIENT_TAG &&
             peek16(pos + 2, be) == tiffop_pkg::ORIENT_TYPE &&
             peek32(pos + 4, be) == tiffop_pkg::ORIENT_COUNT) begin
            r.status      = tiffop_pkg::ST_PATCHED;
            r.offset      = 16'(pos + 8);
            r.first_byte  = be ? tiffop_pkg::ORIENT_TOP_LEFT[15:8]
                               : tiffop_pkg::ORIENT_TOP_LEFT[7:0];
            r.second_byte = be ? tiffop_pkg::ORIENT_TOP_LEFT[7:0]
                               : tiffop_pkg::ORIENT_TOP_LEFT[15:8];
            return r;
         end
         pos += tiffop_pkg::ENTRY_BYTES;
      end
      r.status = tiffop_pkg::ST_NOT_FOUND;
      return r;
   endfunction

   // take one byte into the shadow store; a last byte yields a result
   function automatic void absorb_byte(input logic [7:0] b, input logic l,
                                       output bit got, output patch_rsp_type r);
      got = 1'b0;
      r   = '0;
      if (fill_count < tiffop_pkg::MAX_BYTES) begin
         store_image[fill_count] = b;
         fill_count++;
      end else begin
         spilled = 1'b1;
      end
      if (l) begin
         r          = locate_orientation();
         got        = 1'b1;
         fill_count = 0;
         spilled    = 1'b0;
      end
   endfunction

   function automatic void put16(ref byte_q_type blk, input int unsigned pos,
                                 input logic [15:0] v, input bit be);
      blk[pos]     = be ? v[15:8] : v[7:0];
      blk[pos + 1] = be ? v[7:0] : v[15:8];
   endfunction

   function automatic void put32(ref byte_q_type blk, input int unsigned pos,
                                 input logic [31:0] v, input bit be);
      put16(blk, pos + (be ? 0 : 2), v[31:16], be);
      put16(blk, pos + (be ? 2 : 0), v[15:0], be);
   endfunction

   // random block: mostly well-formed ifd tables with near-miss entries,
   // some truncated, with a bad signature, bad offset or bad count, or noise
   function automatic void make_random_block(ref byte_q_type blk);
      bit          be;
      int unsigned kind;
      int unsigned ifd;
      int unsigned n;
      int unsigned total;
      int unsigned pos;
      int unsigned flip;
      logic [15:0] tag;
      logic [15:0] kind_code;
      logic [31:0] cnt;
      logic [31:0] bad_ifd;
      blk.delete();
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 24)) blk.push_back(8'($urandom));
         if (blk.size() >= 4 && $urandom_range(0, 1) == 1) begin
            put32(blk, 0, $urandom_range(0, 1) ? tiffop_pkg::SIG_MM : tiffop_pkg::SIG_II,
                  1'b1);
         end
         return;
      end
      be    = 1'($urandom_range(0, 1));
      ifd   = 8 + $urandom_range(0, 6);
      n     = $urandom_range(0, 6);
      total = ifd + 2 + tiffop_pkg::ENTRY_BYTES * n + $urandom_range(0, 6);
      repeat (total) blk.push_back(8'($urandom));
      put32(blk, 0, be ? tiffop_pkg::SIG_MM : tiffop_pkg::SIG_II, 1'b1);
      put32(blk, 4, ifd, be);
      put16(blk, ifd, 16'(n), be);
      // entries: exact, one bit off, byte-swapped or random fields
      for (int i = 0; i < int'(n); i++) begin
         pos = ifd + 2 + tiffop_pkg::ENTRY_BYTES * i;
         case ($urandom_range(0, 3))
            0: tag = tiffop_pkg::ORIENT_TAG;
            1: tag = tiffop_pkg::ORIENT_TAG ^ (16'd1 << $urandom_range(0, 15));
            2: tag = {tiffop_pkg::ORIENT_TAG[7:0], tiffop_pkg::ORIENT_TAG[15:8]};
            default: tag = 16'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0: kind_code = tiffop_pkg::ORIENT_TYPE;
            1: kind_code = tiffop_pkg::ORIENT_TYPE ^ (16'd1 << $urandom_range(0, 15));
            2: kind_code = {tiffop_pkg::ORIENT_TYPE[7:0], tiffop_pkg::ORIENT_TYPE[15:8]};
            default: kind_code = 16'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0: cnt = tiffop_pkg::ORIENT_COUNT;
            1: cnt = tiffop_pkg::ORIENT_COUNT ^ (32'd1 << $urandom_range(0, 31));
            2: cnt = {tiffop_pkg::ORIENT_COUNT[7:0], tiffop_pkg::ORIENT_COUNT[15:8],
                      tiffop_pkg::ORIENT_COUNT[23:16], tiffop_pkg::ORIENT_COUNT[31:24]};
            default: cnt = $urandom;
         endcase
         put16(blk, pos, tag, be);
         put16(blk, pos + 2, kind_code, be);
         put32(blk, pos + 4, cnt, be);
      end
      // plant one or two exact matches
      if (n != 0 && $urandom_range(0, 99) < 60) begin
         repeat ($urandom_range(1, 2)) begin
            pos = ifd + 2 + tiffop_pkg::ENTRY_BYTES * $urandom_range(0, n - 1);
            put16(blk, pos, tiffop_pkg::ORIENT_TAG, be);
            put16(blk, pos + 2, tiffop_pkg::ORIENT_TYPE, be);
            put32(blk, pos + 4, tiffop_pkg::ORIENT_COUNT, be);
         end
      end
      // damage
      if (kind >= 60 && kind < 72) begin
         pos = $urandom_range(1, total - 1);
         blk = blk[0:pos-1];
      end else if (kind >= 72 && kind < 80) begin
         pos  = $urandom_range(0, 3);
         flip = $urandom_range(0, 7);
         blk[pos] = blk[pos] ^ 8'(1 << flip);
      end else if (kind >= 80 && kind < 90) begin
         case ($urandom_range(0, 6))
            0: bad_ifd = 32'h7FFF_FFFF;
            1: bad_ifd = 32'hFFFF_FFFF;
            2: bad_ifd = 32'h7FFF_FFFE;
            3: bad_ifd = total - 1;
            4: bad_ifd = total - 2;
            5: bad_ifd = total;
            default: bad_ifd = $urandom;
         endcase
         put32(blk, 4, bad_ifd, be);
      end else if (kind >= 90) begin
         put16(blk, ifd, $urandom_range(0, 1) ? 16'(n + $urandom_range(1, 4))
                                              : 16'($urandom), be);
      end
   endfunction

   // drive one byte, wait for its handshake, then predict
   task automatic send_byte(input logic [7:0] b, input logic l, input int unsigned idle_pct,
                            input bit use_typed, input patch_rsp_type typed);
      bit            got;
      patch_rsp_type predicted;
      if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last      <= l;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      absorb_byte(b, l, got, predicted);
      if (got) pending_patches.push_back(use_typed ? typed : predicted);
      @(negedge clock);
   endtask

   function automatic void check_field(input string what, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      patch_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_patches.size() == 0) begin
            $display("%0t: result expected none got status %0d offset %0h", $time,
                     rsp_ch.status, rsp_ch.patch_offset);
            mismatch_count++;
         end else begin
            want = pending_patches.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_ch.status));
            check_field("patch_offset", want.offset, rsp_ch.patch_offset);
            check_field("patch_first_byte", 16'(want.first_byte),
                        16'(rsp_ch.patch_first_byte));
            check_field("patch_second_byte", 16'(want.second_byte),
                        16'(rsp_ch.patch_second_byte));
            check_field("big_endian", 16'(want.big_endian), 16'(rsp_ch.big_endian));
         end
      end
   end

   // receiver stalls in bursts, with calm stretches
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!quiet_tail && !rsp_calm && $urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= $urandom_range(0, 4);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
      if ($urandom_range(0, 149) == 0) rsp_calm <= !rsp_calm;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // stimulus
   initial begin
      byte_q_type  blk;
      int unsigned sent;
      int unsigned blocks;
      int unsigned idle_pct;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.last      = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_ROWS[i]) begin
         send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, 20,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);
      end

      // hold off until every result is back
      req_ch.valid <= 1'b0;
      while (pending_patches.size() != 0) @(negedge clock);

      // random blocks, calm at the tail
      sent   = 0;
      blocks = 0;
      while (sent < RANDOM_BYTES || blocks < MIN_BLOCKS) begin
         if (sent + 150 >= RANDOM_BYTES && blocks + 5 >= MIN_BLOCKS) quiet_tail = 1'b1;
         make_random_block(blk);
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 40;
         endcase
         foreach (blk[i]) send_byte(blk[i], i == blk.size() - 1, idle_pct, 1'b0, NO_PATCH);
         sent += blk.size();
         blocks++;
      end

      // drain
      req_ch.valid <= 1'b0;
      while (pending_patches.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_patches.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
